// ===== rtl/bbcs_pkg.sv =====
// Package with constants, codes and controller interface types for the centroid steering block.
`timescale 1ns / 1ps
package bbcs_pkg;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int CNT_W  = 21;
	localparam int SUM_W  = 30;
	localparam int DIM_W  = 11;
	localparam int PIX_W  = 8;
	localparam int COL_W  = 10;
	localparam int LIN_W  = 15;
	localparam int ANG_W  = 16;
	localparam int NUM_W  = 52;
	localparam int DEN_W  = 35;

	localparam logic [LIN_W-1:0] LIN_MAX      = 15'd19661;
	localparam logic [LIN_W-1:0] LIN_MIN      = 15'd3932;
	localparam logic [LIN_W-1:0] ANG_MAX      = 15'd26214;
	localparam logic [16:0]      CHANGE_LIMIT = 17'd327;
	localparam logic [15:0]      E_MAX        = 16'd32768;
	localparam logic [16:0]      T_LIMIT      = 17'd15729;
	localparam logic [16:0]      RECIP5       = 17'd52429;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_WIDTH     = 2'd1;
	localparam logic [1:0] REG_HEIGHT    = 2'd2;

	localparam logic [1:0] OP_ANG  = 2'd0;
	localparam logic [1:0] OP_ERR  = 2'd1;
	localparam logic [1:0] OP_FRAC = 2'd2;

	typedef struct packed {
		logic       prep;
		logic       div_start;
		logic [1:0] div_op;
		logic       mul;
		logic       send;
	} ctrl_cmd_t;

	typedef struct packed {
		logic zero;
		logic div_done;
		logic out_free;
	} dp_status_t;
endpackage

// ===== rtl/bright_blob_centroid_steering.sv =====
// Top level of the bright blob centroid steering block.
//  channel   direction  handshake              payload
//  s_*       in         s_tvalid / s_tready    s_tdata pixel, s_tlast frame end
//  m_*       out        m_tvalid / m_tready    m_tdata drive command
//  cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
// Ordinary pixels are accepted while the block is accumulating. A frame-end pixel holds
// off the next request through setup, three runs of the shared 52-step divider, the final
// multiply and the handoff; with a zero frame size or no white pixel the divisions and
// multiply are skipped. Reset is asynchronous and active low. A pending command waits in
// the output register while new pixels are taken; a frame-end handoff stalls only if it is full.
`timescale 1ns / 1ps
module bright_blob_centroid_steering #(
	parameter int MAX_WIDTH  = bbcs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bbcs_pkg::DEF_MAX_HEIGHT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [39:0]                s_tdata,   // red, green, blue, column, zero pad
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,   // linear_speed, angular_speed, zero pad
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [bbcs_pkg::DIM_W-1:0] cfg_data
);
	import bbcs_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	bbcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bbcs_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_acc   (s_tvalid & s_tready),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);
endmodule

// ===== rtl/bbcs_div.sv =====
// Restoring divider with round-half-up, one quotient bit per cycle.
`timescale 1ns / 1ps
module bbcs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bbcs_pkg::NUM_W-1:0]  num,
	input  logic [bbcs_pkg::DEN_W-1:0]  den,
	output logic                        done,
	output logic [bbcs_pkg::NUM_W-1:0]  quot
);
	import bbcs_pkg::*;

	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num + NUM_W'(den >> 1);
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? shifted - {1'b0, den_q} : shifted;
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = num_q;
endmodule

// ===== rtl/bbcs_ctrl.sv =====
// Controller state machine sequencing accumulation and the per-frame command computation.
`timescale 1ns / 1ps
module bbcs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tlast,
	output logic                   s_tready,
	input  bbcs_pkg::dp_status_t   status,
	output bbcs_pkg::ctrl_cmd_t    cmd
);
	import bbcs_pkg::*;

	localparam logic [3:0] ST_ACC  = 4'd0;
	localparam logic [3:0] ST_PREP = 4'd1;
	localparam logic [3:0] ST_CHK  = 4'd2;
	localparam logic [3:0] ST_DIVA = 4'd3;
	localparam logic [3:0] ST_DIVE = 4'd4;
	localparam logic [3:0] ST_DIVT = 4'd5;
	localparam logic [3:0] ST_MUL  = 4'd6;
	localparam logic [3:0] ST_FIN  = 4'd7;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_ACC;
		else state_q <= state_d;
	end

	assign s_tready = state_q == ST_ACC;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_ACC: begin
				if (s_tvalid && s_tlast) state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_CHK;
			end
			ST_CHK: begin
				if (status.zero) begin
					state_d = ST_FIN;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_op    = OP_ANG;
					state_d       = ST_DIVA;
				end
			end
			ST_DIVA: begin
				if (status.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = OP_ERR;
					state_d       = ST_DIVE;
				end
			end
			ST_DIVE: begin
				if (status.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = OP_FRAC;
					state_d       = ST_DIVT;
				end
			end
			ST_DIVT: begin
				if (status.div_done) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.send = 1'b1;
					state_d  = ST_ACC;
				end
			end
			default: state_d = ST_ACC;
		endcase
	end
endmodule

// ===== rtl/bbcs_dpath.sv =====
// Datapath with accumulators, configuration registers, divider operands and output register.
`timescale 1ns / 1ps
module bbcs_dpath #(
	parameter int MAX_WIDTH  = bbcs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bbcs_pkg::DEF_MAX_HEIGHT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic [1:0]                 cfg_index,
	input  logic [bbcs_pkg::DIM_W-1:0] cfg_data,
	input  logic                       pix_acc,
	input  logic [39:0]                s_tdata,
	input  bbcs_pkg::ctrl_cmd_t        cmd,
	output bbcs_pkg::dp_status_t       status,
	input  logic                       m_tready,
	output logic                       m_tvalid,
	output logic [31:0]                m_tdata
);
	import bbcs_pkg::*;

	logic [PIX_W-1:0] thr_q;
	logic [DIM_W-1:0] cfg_w_q, cfg_h_q, w_q, h_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [31:0]      d_q, mag_q;
	logic [21:0]      wh_q;
	logic             neg_q;
	logic [1:0]       op_q;
	logic signed [ANG_W-1:0] ang_q, last_ang_q;
	logic [LIN_W-1:0] lin_q, last_lin_q, base_q;
	logic [15:0]      e_q, pen_q;
	logic             out_valid_q;
	logic [31:0]      out_q;

	logic [PIX_W-1:0] red, green, blue;
	logic [COL_W-1:0] column;
	logic             white;
	logic [SUM_W:0]   sum_next;
	logic [DIM_W-1:0] w_clamp, h_clamp;
	logic [31:0]      d_next;
	logic [30:0]      twice_sum;
	logic [NUM_W-1:0] div_num, quot;
	logic [DEN_W-1:0] div_den;
	logic             div_done;
	logic [33:0]      mag3;
	logic [23:0]      cnt5;
	logic [17:0]      e3;
	logic [33:0]      pen_div;
	logic [LIN_W-1:0] a_mag;
	logic [30:0]      prod;
	logic [16:0]      dlin, dang;
	logic             changed;

	assign red    = s_tdata[7:0];
	assign green  = s_tdata[15:8];
	assign blue   = s_tdata[23:16];
	assign column = s_tdata[33:24];
	assign white  = red >= thr_q && green >= thr_q && blue >= thr_q;
	assign sum_next = {1'b0, sum_q} + (SUM_W+1)'(column);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= 8'd200;
			cfg_w_q <= 11'd640;
			cfg_h_q <= 11'd480;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q <= cfg_data[PIX_W-1:0];
				REG_WIDTH:     cfg_w_q <= cfg_data;
				REG_HEIGHT:    cfg_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (cmd.send) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (pix_acc && white) begin
			if (count_q != '1) count_q <= count_q + 1'b1;
			sum_q <= sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
		end
	end

	assign w_clamp = (13'(cfg_w_q) > 13'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg_w_q;
	assign h_clamp = (13'(cfg_h_q) > 13'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_h_q;
	assign d_next    = 32'(w_clamp) * 32'(count_q);
	assign twice_sum = {sum_q, 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			w_q   <= w_clamp;
			h_q   <= h_clamp;
			d_q   <= d_next;
			wh_q  <= 22'(w_clamp) * 22'(h_clamp);
			neg_q <= d_next < 32'(twice_sum);
			mag_q <= (d_next >= 32'(twice_sum)) ? d_next - 32'(twice_sum)
			                                    : 32'(twice_sum) - d_next;
			lin_q <= '0;
			ang_q <= '0;
		end
		if (cmd.div_start) op_q <= cmd.div_op;
		if (div_done) begin
			case (op_q)
				OP_ANG:  ang_q <= neg_q ? -$signed({1'b0, a_mag}) : $signed({1'b0, a_mag});
				OP_ERR:  e_q <= (quot > NUM_W'(E_MAX)) ? E_MAX : quot[15:0];
				default: begin
					base_q <= (quot > NUM_W'(T_LIMIT)) ? LIN_MIN : LIN_MAX - quot[LIN_W-1:0];
					pen_q  <= E_MAX - pen_div[33:18];
				end
			endcase
		end
		if (cmd.mul) lin_q <= prod[29:15];
	end

	assign a_mag = (quot > NUM_W'(ANG_MAX)) ? ANG_MAX : quot[LIN_W-1:0];
	assign prod  = 31'(base_q) * 31'(pen_q) + 31'd16384;

	assign mag3 = {mag_q, 1'b0} + 34'(mag_q);
	assign cnt5 = {1'b0, count_q, 2'b00} + 24'(count_q);
	assign e3   = {1'b0, e_q, 1'b0} + 18'(e_q);

	// Rounded division of 3e by five through a reciprocal multiply.
	assign pen_div = (34'(e3) + 34'd2) * 34'(RECIP5);

	always_comb begin
		case (cmd.div_op)
			OP_ANG: begin
				div_num = NUM_W'({mag3, 16'd0});
				div_den = DEN_W'({d_q, 2'b00}) + DEN_W'(d_q);
			end
			OP_ERR: begin
				div_num = NUM_W'({mag_q, 15'd0});
				div_den = DEN_W'(d_q);
			end
			default: begin
				div_num = NUM_W'({cnt5, 14'd0});
				div_den = DEN_W'(wh_q);
			end
		endcase
	end

	bbcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (quot)
	);

	assign dlin = {2'b00, lin_q} - {2'b00, last_lin_q};
	assign dang = {ang_q[ANG_W-1], ang_q} - {last_ang_q[ANG_W-1], last_ang_q};
	assign changed = ($signed(dlin) > $signed(CHANGE_LIMIT)) ||
	                 ($signed(dlin) < -$signed(CHANGE_LIMIT)) ||
	                 ($signed(dang) > $signed(CHANGE_LIMIT)) ||
	                 ($signed(dang) < -$signed(CHANGE_LIMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_lin_q  <= '0;
			last_ang_q  <= '0;
		end else begin
			if (m_tready) out_valid_q <= 1'b0;
			if (cmd.send && changed) begin
				out_valid_q <= 1'b1;
				last_lin_q  <= lin_q;
				last_ang_q  <= ang_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.send && changed) out_q <= {1'b0, ang_q, lin_q};
	end

	assign status.zero     = w_q == '0 || h_q == '0 || d_q == '0;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
endmodule

// ===== test/bbcs_checker.sv =====
// Checker that predicts and compares drive commands of the centroid steering block.
`timescale 1ns / 1ps
module bbcs_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [39:0]                s_tdata,
	input  logic                       s_tlast,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [31:0]                m_tdata,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [bbcs_pkg::DIM_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending
);
	import bbcs_pkg::*;

	typedef struct packed {
		logic [LIN_W-1:0] lin;
		logic [ANG_W-1:0] ang;
	} drive_cmd_t;

	drive_cmd_t cmd_q[$];

	longint unsigned thr, width, height, white_cnt, col_sum;
	int last_lin, last_ang;

	function automatic longint unsigned rdiv(longint unsigned num, longint unsigned den);
		return (num + den / 2) / den;
	endfunction

	task automatic steer_from_blob(input longint unsigned cnt, input longint unsigned sum,
			output int lin, output int ang);
		longint unsigned w, h, d, twice, mag, a, e, t, pen;
		longint base;
		bit neg;
		w = width > 1024 ? 1024 : width;
		h = height > 1024 ? 1024 : height;
		lin = 0;
		ang = 0;
		if (w == 0 || h == 0 || cnt == 0)
			return;
		d = w * cnt;
		twice = 2 * sum;
		neg = twice > d;
		mag = neg ? twice - d : d - twice;
		a = rdiv(196608 * mag, 5 * d);
		if (a > 26214)
			a = 26214;
		ang = neg ? -int'(a) : int'(a);
		e = rdiv(mag * 32768, d);
		if (e > 32768)
			e = 32768;
		t = rdiv(81920 * cnt, w * h);
		if (t > 100000)
			t = 100000;
		base = 19661 - longint'(t);
		if (base < 3932)
			base = 3932;
		pen = 32768 - rdiv(3 * e, 5);
		lin = int'(rdiv(longint'(unsigned'(base)) * pen, 32768));
	endtask

	assign pending = cmd_q.size();

	always @(posedge clk or negedge arst_n) begin
		int lin, ang, dl, da;
		drive_cmd_t exp_cmd;
		if (!arst_n) begin
			thr = 200;
			width = 640;
			height = 480;
			white_cnt = 0;
			col_sum = 0;
			last_lin = 0;
			last_ang = 0;
			fail_count = 0;
			cmd_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (cmd_q.size() == 0) begin
					$error("unexpected command lin=%0d ang=%0d", m_tdata[14:0],
						$signed(m_tdata[30:15]));
					fail_count++;
				end else begin
					exp_cmd = cmd_q.pop_front();
					if (m_tdata[14:0] !== exp_cmd.lin) begin
						$error("linear_speed expected %0d got %0d", exp_cmd.lin, m_tdata[14:0]);
						fail_count++;
					end
					if (m_tdata[30:15] !== exp_cmd.ang) begin
						$error("angular_speed expected %0d got %0d", $signed(exp_cmd.ang),
							$signed(m_tdata[30:15]));
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_THRESHOLD: thr = cfg_data[7:0];
					REG_WIDTH: width = cfg_data;
					REG_HEIGHT: height = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tdata[7:0] >= thr && s_tdata[15:8] >= thr && s_tdata[23:16] >= thr) begin
					if (white_cnt < (1 << 21) - 1)
						white_cnt++;
					col_sum += s_tdata[33:24];
					if (col_sum > (1 << 30) - 1)
						col_sum = (1 << 30) - 1;
				end
				if (s_tlast) begin
					steer_from_blob(white_cnt, col_sum, lin, ang);
					white_cnt = 0;
					col_sum = 0;
					dl = lin > last_lin ? lin - last_lin : last_lin - lin;
					da = ang > last_ang ? ang - last_ang : last_ang - ang;
					if (dl > 327 || da > 327) begin
						last_lin = lin;
						last_ang = ang;
						exp_cmd.lin = lin[14:0];
						exp_cmd.ang = ang[15:0];
						cmd_q.push_back(exp_cmd);
					end
				end
			end
		end
	end
endmodule

// ===== test/tb_bright_blob_centroid_steering.sv =====
// Testbench top that drives pixel frames and register writes into the steering block.
`timescale 1ns / 1ps
module tb_bright_blob_centroid_steering;
	import bbcs_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        s_tlast = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [31:0] m_tdata;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_THRESHOLD;
	logic [DIM_W-1:0] cfg_data = '0;
	int fail_count, pending;
	int gap_pct = 0, stall_pct = 0, quiet_cycles = 0;
	int cur_thr = 200, cur_w = 640;

	bright_blob_centroid_steering i_dut (.*);

	bbcs_checker i_checker (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 20000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_pixel(input int r, input int g, input int b, input int col,
			input bit last);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			s_tvalid <= 0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		s_tvalid <= 1;
		s_tdata <= {6'd0, col[9:0], b[7:0], g[7:0], r[7:0]};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain_commands();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int value);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value[DIM_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_THRESHOLD)
			cur_thr = value & 8'hFF;
		if (idx == REG_WIDTH)
			cur_w = value;
	endtask

	task automatic configure(input int thr, input int w, input int h);
		drain_commands();
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		cfg_valid <= 0;
	endtask

	task automatic random_frame(output int n);
		int white_pct, lim, col;
		bit white;
		n = $urandom_range(12, 1);
		white_pct = $urandom_range(100);
		lim = cur_w > 1024 ? 1024 : cur_w;
		for (int k = 0; k < n; k++) begin
			white = $urandom_range(99) < white_pct;
			if (lim > 0 && $urandom_range(9) != 0)
				col = $urandom_range(lim - 1);
			else
				col = $urandom_range(1023);
			if (white)
				send_pixel($urandom_range(255, cur_thr), $urandom_range(255, cur_thr),
					$urandom_range(255, cur_thr), col, k == n - 1);
			else
				send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255), col,
					k == n - 1);
		end
	endtask

	initial begin
		int sent, n, thr, w, h;
		int thr_set[4] = '{200, 0, 255, 128};
		int w_set[7] = '{640, 1, 0, 1024, 2047, 2, 37};
		int h_set[6] = '{480, 1, 1024, 0, 2047, 3};
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_pixel(255, 255, 255, 0, 1);
		send_pixel(255, 255, 255, 0, 1);
		send_pixel(0, 0, 0, 1023, 1);
		send_pixel(255, 255, 255, 639, 0);
		send_pixel(200, 200, 200, 600, 0);
		send_pixel(199, 255, 255, 5, 1);
		send_pixel(255, 199, 255, 5, 0);
		send_pixel(255, 255, 199, 5, 1);
		configure(0, 0, 480);
		send_pixel(0, 0, 0, 10, 1);
		configure(255, 1, 1);
		send_pixel(255, 255, 255, 1023, 1);
		send_pixel(254, 255, 255, 0, 1);
		configure(200, 2047, 2047);
		send_pixel(255, 255, 255, 1023, 0);
		send_pixel(255, 255, 255, 1000, 1);
		configure(10, 640, 0);
		send_pixel(255, 255, 255, 3, 1);
		sent = 0;
		for (int blk = 0; blk < 12; blk++) begin
			gap_pct = (blk % 4 == 1) ? 60 : (blk % 4 == 3) ? 8 : 0;
			stall_pct = (blk % 4 == 2) ? 60 : (blk % 4 == 3) ? 8 : 0;
			thr = (blk < 4) ? thr_set[blk] : $urandom_range(255);
			w = (blk < 7) ? w_set[blk] : $urandom_range(1024);
			h = (blk < 6) ? h_set[blk] : $urandom_range(1024);
			configure(thr, w, h);
			for (int f = 0; f < 74; f += n) begin
				random_frame(n);
				sent += n;
				if (blk == 0 && f > 40 && f < 45) begin
					s_tvalid <= 0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
			end
		end
		drain_commands();
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
